// ===== design/fsba_pkg.sv =====
`default_nettype none

package fsba_pkg;

	localparam int PIX_W       = 16;
	localparam int SUM_W       = 32;
	localparam int FRAC_W      = 8;
	localparam int DIVIDEND_W  = SUM_W + FRAC_W;
	localparam int DIV_CNT_W   = 6;
	localparam int AVG_W       = 24;
	localparam int COORD_W     = 8;
	localparam int CFG_W       = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int BIN_REG_W   = 5;
	localparam int FRAME_REG_W = 7;
	localparam int DIM_REG_W   = 9;

	localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT  = 2'd3;

	localparam logic [AVG_W-1:0] AVG_MAX = 24'h7FFFFF;
	localparam logic [AVG_W-1:0] AVG_MIN = 24'h800000;

	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic write_back;
		logic div_start;
		logic out_load;
	} fsba_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic emit;
		logic div_done;
		logic out_free;
	} fsba_status_t;

endpackage

`default_nettype wire

// ===== design/frame_stack_bin_average_top.sv =====
// Each pixel beat is accepted, then its accumulator entry is read-modify-written.
// A beat that completes a block in the last frame then starts the 40-step
// radix-2 divider; its average is loaded into the output register once the
// divider is done and the output is free. Only then is the next beat taken.
// After reset the accumulator memory is swept to zero, one entry per cycle,
// all MAX_OUT_WIDTH*MAX_OUT_HEIGHT entries (65536 by default), input stalled.
`default_nettype none

module frame_stack_bin_average_top #(
	parameter int MAX_OUT_WIDTH  = 256,
	parameter int MAX_OUT_HEIGHT = 256,
	parameter int MAX_BIN        = 16,
	parameter int MAX_FRAMES     = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [fsba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fsba_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [fsba_pkg::PIX_W-1:0] pixel_value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [fsba_pkg::AVG_W-1:0]      average,
	output logic [fsba_pkg::COORD_W-1:0]           out_x,
	output logic [fsba_pkg::COORD_W-1:0]           out_y,
	output logic                                   last_of_image
);
	import fsba_pkg::*;

	fsba_cmd_t    cmd;
	fsba_status_t status;

	fsba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	fsba_datapath #(
		.MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
		.MAX_OUT_HEIGHT (MAX_OUT_HEIGHT),
		.MAX_BIN        (MAX_BIN),
		.MAX_FRAMES     (MAX_FRAMES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixel_value   (pixel_value),
		.cmd           (cmd),
		.status        (status),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.average       (average),
		.out_x         (out_x),
		.out_y         (out_y),
		.last_of_image (last_of_image)
	);

endmodule

`default_nettype wire

// ===== design/fsba_div.sv =====
`default_nettype none

module fsba_div #(
	parameter int DEN_W = 15
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [fsba_pkg::DIVIDEND_W-1:0]   dividend,
	input  wire logic [DEN_W-1:0]                  divisor,
	output logic                                   done,
	output logic [fsba_pkg::DIVIDEND_W-1:0]        quotient
);
	import fsba_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DEN_W-1:0]      rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DEN_W-1:0]      den_q;
	logic [DEN_W:0]        rem_shift;
	logic                  fits;

	assign rem_shift = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits      = rem_shift >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DEN_W'(rem_shift - {1'b0, den_q});
			end else begin
				rem_q <= DEN_W'(rem_shift);
			end
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== design/fsba_datapath.sv =====
`default_nettype none

module fsba_datapath #(
	parameter int MAX_OUT_WIDTH  = 256,
	parameter int MAX_OUT_HEIGHT = 256,
	parameter int MAX_BIN        = 16,
	parameter int MAX_FRAMES     = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [fsba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fsba_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic signed [fsba_pkg::PIX_W-1:0] pixel_value,
	input  wire fsba_pkg::fsba_cmd_t              cmd,
	output fsba_pkg::fsba_status_t                status,
	input  wire logic                             out_stall,
	output logic                                  out_valid,
	output logic signed [fsba_pkg::AVG_W-1:0]     average,
	output logic [fsba_pkg::COORD_W-1:0]          out_x,
	output logic [fsba_pkg::COORD_W-1:0]          out_y,
	output logic                                  last_of_image
);
	import fsba_pkg::*;

	localparam int DEPTH  = MAX_OUT_WIDTH * MAX_OUT_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_W  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
	localparam int ROW_W  = (MAX_OUT_HEIGHT > 1) ? $clog2(MAX_OUT_HEIGHT) : 1;
	localparam int SUB_W  = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1;
	localparam int FI_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int BS_W   = $clog2(MAX_BIN + 1);
	localparam int FC_W   = $clog2(MAX_FRAMES + 1);
	localparam int OW_W   = $clog2(MAX_OUT_WIDTH + 1);
	localparam int OH_W   = $clog2(MAX_OUT_HEIGHT + 1);
	localparam int DEN_W  = $clog2(MAX_BIN * MAX_BIN * MAX_FRAMES + 1);

	logic [BIN_REG_W-1:0]   bin_size_q;
	logic [FRAME_REG_W-1:0] frame_count_q;
	logic [DIM_REG_W-1:0]   out_width_q;
	logic [DIM_REG_W-1:0]   out_height_q;

	logic [BS_W-1:0]  bs;
	logic [FC_W-1:0]  fc;
	logic [OW_W-1:0]  ow;
	logic [OH_W-1:0]  oh;
	logic [DEN_W-1:0] den_q;

	logic [FI_W-1:0]  frame_idx_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [SUB_W-1:0] rib_q;
	logic [SUB_W-1:0] cib_q;

	logic             col_wrap;
	logic             bcol_wrap;
	logic             rib_wrap;
	logic             row_wrap;
	logic             fi_wrap;
	logic             emit_now;
	logic             last_now;
	logic [ADDR_W-1:0] cur_addr;

	logic [SUM_W-1:0]  mem [DEPTH];
	logic [SUM_W-1:0]  rd_data_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PIX_W-1:0]  pix_q;
	logic              emit_q;
	logic              last_q;
	logic [COL_W-1:0]  x_q;
	logic [ROW_W-1:0]  y_q;
	logic              neg_q;

	logic [SUM_W-1:0]      sum;
	logic [SUM_W-1:0]      sum_mag;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [SUM_W-1:0]      wr_data;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] quotient;
	logic [AVG_W-1:0]      avg;

	logic                  out_valid_q;
	logic [AVG_W-1:0]      avg_q;
	logic [COORD_W-1:0]    out_x_q;
	logic [COORD_W-1:0]    out_y_q;
	logic                  last_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_size_q    <= BIN_REG_W'(1);
			frame_count_q <= FRAME_REG_W'(1);
			out_width_q   <= DIM_REG_W'(256);
			out_height_q  <= DIM_REG_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIN_SIZE:    bin_size_q    <= cfg_data[BIN_REG_W-1:0];
				REG_FRAME_COUNT: frame_count_q <= cfg_data[FRAME_REG_W-1:0];
				REG_OUT_WIDTH:   out_width_q   <= cfg_data[DIM_REG_W-1:0];
				REG_OUT_HEIGHT:  out_height_q  <= cfg_data[DIM_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bin_size_q == '0) begin
			bs = BS_W'(1);
		end else if (32'(bin_size_q) > 32'(MAX_BIN)) begin
			bs = BS_W'(MAX_BIN);
		end else begin
			bs = BS_W'(bin_size_q);
		end
		if (frame_count_q == '0) begin
			fc = FC_W'(1);
		end else if (32'(frame_count_q) > 32'(MAX_FRAMES)) begin
			fc = FC_W'(MAX_FRAMES);
		end else begin
			fc = FC_W'(frame_count_q);
		end
		if (out_width_q == '0) begin
			ow = OW_W'(1);
		end else if (32'(out_width_q) > 32'(MAX_OUT_WIDTH)) begin
			ow = OW_W'(MAX_OUT_WIDTH);
		end else begin
			ow = OW_W'(out_width_q);
		end
		if (out_height_q == '0) begin
			oh = OH_W'(1);
		end else if (32'(out_height_q) > 32'(MAX_OUT_HEIGHT)) begin
			oh = OH_W'(MAX_OUT_HEIGHT);
		end else begin
			oh = OH_W'(out_height_q);
		end
	end

	assign col_wrap  = 32'(cib_q) + 32'd1 >= 32'(bs);
	assign bcol_wrap = 32'(col_q) + 32'd1 >= 32'(ow);
	assign rib_wrap  = 32'(rib_q) + 32'd1 >= 32'(bs);
	assign row_wrap  = 32'(row_q) + 32'd1 >= 32'(oh);
	assign fi_wrap   = 32'(frame_idx_q) + 32'd1 >= 32'(fc);

	assign emit_now = (32'(frame_idx_q) == 32'(fc) - 32'd1)
		&& (32'(rib_q) == 32'(bs) - 32'd1)
		&& (32'(cib_q) == 32'(bs) - 32'd1);
	assign last_now = (32'(row_q) == 32'(oh) - 32'd1)
		&& (32'(col_q) == 32'(ow) - 32'd1);
	assign cur_addr = ADDR_W'(32'(row_q) * MAX_OUT_WIDTH + 32'(col_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_idx_q <= '0;
			row_q       <= '0;
			col_q       <= '0;
			rib_q       <= '0;
			cib_q       <= '0;
		end else if (cmd.accept) begin
			if (!col_wrap) begin
				cib_q <= SUB_W'(32'(cib_q) + 32'd1);
			end else begin
				cib_q <= '0;
				if (!bcol_wrap) begin
					col_q <= COL_W'(32'(col_q) + 32'd1);
				end else begin
					col_q <= '0;
					if (!rib_wrap) begin
						rib_q <= SUB_W'(32'(rib_q) + 32'd1);
					end else begin
						rib_q <= '0;
						if (!row_wrap) begin
							row_q <= ROW_W'(32'(row_q) + 32'd1);
						end else begin
							row_q <= '0;
							if (!fi_wrap) begin
								frame_idx_q <= FI_W'(32'(frame_idx_q) + 32'd1);
							end else begin
								frame_idx_q <= '0;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= cur_addr;
			pix_q  <= pixel_value;
			emit_q <= emit_now;
			last_q <= last_now;
			x_q    <= col_q;
			y_q    <= row_q;
			den_q  <= DEN_W'(32'(bs) * 32'(bs) * 32'(fc));
		end
		if (cmd.write_back) begin
			neg_q <= sum[SUM_W-1];
		end
	end

	assign sum     = rd_data_q + {{(SUM_W - PIX_W){pix_q[PIX_W-1]}}, pix_q};
	assign sum_mag = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;

	assign wr_en   = cmd.clear_wr | cmd.write_back;
	assign wr_addr = cmd.clear_wr ? clr_addr_q : addr_q;
	assign wr_data = (cmd.clear_wr || emit_q) ? '0 : sum;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.accept) begin
			rd_data_q <= mem[cur_addr];
		end
	end

	fsba_div #(
		.DEN_W(DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({sum_mag, {FRAC_W{1'b0}}}),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		if (!neg_q) begin
			if (quotient > DIVIDEND_W'(AVG_MAX)) begin
				avg = AVG_MAX;
			end else begin
				avg = quotient[AVG_W-1:0];
			end
		end else begin
			if (quotient > DIVIDEND_W'(AVG_MIN)) begin
				avg = AVG_MIN;
			end else begin
				avg = ~quotient[AVG_W-1:0] + AVG_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			avg_q      <= avg;
			out_x_q    <= COORD_W'(x_q);
			out_y_q    <= COORD_W'(y_q);
			last_out_q <= last_q;
		end
	end

	assign status.clear_done = clr_addr_q == ADDR_W'(DEPTH - 1);
	assign status.emit       = emit_q;
	assign status.div_done   = div_done;
	assign status.out_free   = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign average       = avg_q;
	assign out_x         = out_x_q;
	assign out_y         = out_y_q;
	assign last_of_image = last_out_q;

endmodule

`default_nettype wire

// ===== design/fsba_ctrl.sv =====
`default_nettype none

module fsba_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire fsba_pkg::fsba_status_t status,
	output fsba_pkg::fsba_cmd_t         cmd
);
	import fsba_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		in_stall       = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.write_back = 1'b1;
				if (status.emit) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire
